// File: design/slpq_pkg.sv
// ----------------------------------------------------------------------------
// slpq_pkg - shared types and constants for the sorted list priority queue
// Capacity, index widths, command and status codes, and the beat structs
// passed between the front and back parts of the queue.
// ----------------------------------------------------------------------------
package slpq_pkg;

  localparam int CAPACITY = 64;
  localparam int CELL_W   = $clog2(CAPACITY);
  localparam int IDX_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 16;
  localparam int HANDLE_W = 16;
  localparam int OCC_W    = 7;
  localparam int STATUS_W = 2;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CELL_W-1:0]   cell_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [OCC_W-1:0]    occ_t;

  // Link value meaning "no cell"
  localparam idx_t NIL_IDX    = idx_t'(CAPACITY);
  localparam idx_t FULL_COUNT = idx_t'(CAPACITY);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic    command;
    key_t    key;
    handle_t item_handle;
  } cmd_t;

  typedef struct packed {
    status_t status;
    key_t    popped_key;
    handle_t popped_handle;
    occ_t    occupied;
  } res_t;

endpackage

// File: design/slpq_front.sv
// ----------------------------------------------------------------------------
// slpq_front - command intake
// Takes input beats, packs them into commands and holds them in a two-entry
// queue so intake continues while the back part is busy.
// ----------------------------------------------------------------------------
module slpq_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_command,
  input  slpq_pkg::key_t         in_key,
  input  slpq_pkg::handle_t      in_item_handle,
  output logic                   q_valid,
  input  logic                   q_ready,
  output slpq_pkg::cmd_t         q_cmd
);

  slpq_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  logic           push, pop;
  slpq_pkg::cmd_t in_cmd;

  assign in_cmd   = '{command: in_command, key: in_key, item_handle: in_item_handle};
  assign in_ready = (fill_r != 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_cmd    = entry_r[rd_ptr_r];
  assign push     = in_valid & in_ready;
  assign pop      = q_valid & q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (push) begin
      entry_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// File: design/slpq_back.sv
// ----------------------------------------------------------------------------
// slpq_back - list engine
// Runs one command at a time against the linked list held in four memories,
// walking back from the tail on insert, and registers the result beat.
// ----------------------------------------------------------------------------
module slpq_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  slpq_pkg::cmd_t q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output slpq_pkg::res_t out_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_TAKE,
    S_WALK,
    S_FIND,
    S_LINK2,
    S_HEAD2,
    S_POP
  } state_t;

  function automatic slpq_pkg::cell_t cell_of(slpq_pkg::idx_t i);
    return i[slpq_pkg::CELL_W-1:0];
  endfunction

  // memories
  slpq_pkg::key_t    key_mem_r    [slpq_pkg::CAPACITY];
  slpq_pkg::handle_t handle_mem_r [slpq_pkg::CAPACITY];
  slpq_pkg::idx_t    next_mem_r   [slpq_pkg::CAPACITY];
  slpq_pkg::idx_t    prev_mem_r   [slpq_pkg::CAPACITY];
  logic [slpq_pkg::CAPACITY-1:0] next_vld_r;

  slpq_pkg::key_t    key_rd_r;
  slpq_pkg::handle_t handle_rd_r;
  slpq_pkg::idx_t    next_rd_r, prev_rd_r;
  logic              next_vld_rd_r;
  slpq_pkg::cell_t   next_raddr_r;
  slpq_pkg::idx_t    next_q;

  logic              key_we, handle_we, next_we, prev_we;
  slpq_pkg::cell_t   key_waddr, next_waddr, prev_waddr;
  slpq_pkg::key_t    key_wdata;
  slpq_pkg::handle_t handle_wdata;
  slpq_pkg::idx_t    next_wdata, prev_wdata;
  slpq_pkg::cell_t   key_raddr, handle_raddr, next_raddr, prev_raddr;

  // control and datapath registers
  state_t            state_r, state_nxt;
  slpq_pkg::idx_t    head_r, head_nxt;
  slpq_pkg::idx_t    tail_r, tail_nxt;
  slpq_pkg::idx_t    free_head_r, free_head_nxt;
  slpq_pkg::idx_t    count_r, count_nxt;
  slpq_pkg::idx_t    j_r, j_nxt;
  slpq_pkg::idx_t    x_r, x_nxt;
  slpq_pkg::idx_t    after_r, after_nxt;
  slpq_pkg::key_t    key_r, key_nxt;
  logic              out_valid_r, out_valid_nxt;
  slpq_pkg::res_t    out_res_r, out_res_nxt;

  logic              finish;
  slpq_pkg::status_t fin_status;
  slpq_pkg::key_t    fin_pk;
  slpq_pkg::handle_t fin_ph;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // never-written link cells read as their reset chain value i+1
  assign next_q = next_vld_rd_r ? next_rd_r
                                : slpq_pkg::idx_t'(next_raddr_r) + slpq_pkg::idx_t'(1);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    j_nxt         = j_r;
    x_nxt         = x_r;
    after_nxt     = after_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_res_nxt   = out_res_r;
    q_ready       = 1'b0;

    key_we       = 1'b0;
    handle_we    = 1'b0;
    next_we      = 1'b0;
    prev_we      = 1'b0;
    key_waddr    = cell_of(j_r);
    key_wdata    = key_r;
    handle_wdata = '0;
    next_waddr   = cell_of(j_r);
    next_wdata   = slpq_pkg::NIL_IDX;
    prev_waddr   = cell_of(j_r);
    prev_wdata   = slpq_pkg::NIL_IDX;
    key_raddr    = cell_of(x_r);
    prev_raddr   = cell_of(x_r);
    handle_raddr = cell_of(head_r);
    next_raddr   = cell_of(j_r);

    finish     = 1'b0;
    fin_status = slpq_pkg::ST_OK;
    fin_pk     = '0;
    fin_ph     = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_ready = 1'b1;
          key_nxt = q_cmd.key;
          if (q_cmd.command == slpq_pkg::CMD_POP) begin
            if (head_r == slpq_pkg::NIL_IDX) begin
              finish     = 1'b1;
              fin_status = slpq_pkg::ST_EMPTY;
            end else begin
              count_nxt    = count_r - slpq_pkg::idx_t'(1);
              key_raddr    = cell_of(head_r);
              handle_raddr = cell_of(head_r);
              next_raddr   = cell_of(head_r);
              state_nxt    = S_POP;
            end
          end else begin
            if (count_r == slpq_pkg::FULL_COUNT) begin
              finish     = 1'b1;
              fin_status = slpq_pkg::ST_FULL;
            end else begin
              count_nxt    = count_r + slpq_pkg::idx_t'(1);
              j_nxt        = free_head_r;
              key_we       = 1'b1;
              key_waddr    = cell_of(free_head_r);
              key_wdata    = q_cmd.key;
              handle_we    = 1'b1;
              handle_wdata = q_cmd.item_handle;
              next_raddr   = cell_of(free_head_r);
              state_nxt    = S_INS_TAKE;
            end
          end
        end
      end
      S_INS_TAKE: begin
        free_head_nxt = next_q;
        if (head_r == slpq_pkg::NIL_IDX) begin
          head_nxt = j_r;
          tail_nxt = j_r;
          next_we  = 1'b1;
          prev_we  = 1'b1;
          finish   = 1'b1;
        end else begin
          x_nxt      = tail_r;
          key_raddr  = cell_of(tail_r);
          prev_raddr = cell_of(tail_r);
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        // one list step a cycle; equal keys stop the walk
        if (key_rd_r > key_r) begin
          if (prev_rd_r == slpq_pkg::NIL_IDX) begin
            next_we    = 1'b1;
            next_wdata = head_r;
            prev_we    = 1'b1;
            x_nxt      = head_r;
            head_nxt   = j_r;
            state_nxt  = S_HEAD2;
          end else begin
            x_nxt      = prev_rd_r;
            key_raddr  = cell_of(prev_rd_r);
            prev_raddr = cell_of(prev_rd_r);
          end
        end else begin
          next_raddr = cell_of(x_r);
          state_nxt  = S_FIND;
        end
      end
      S_FIND: begin
        after_nxt  = next_q;
        next_we    = 1'b1;
        next_waddr = cell_of(x_r);
        next_wdata = j_r;
        prev_we    = 1'b1;
        prev_wdata = x_r;
        state_nxt  = S_LINK2;
      end
      S_LINK2: begin
        next_we    = 1'b1;
        next_wdata = after_r;
        if (after_r != slpq_pkg::NIL_IDX) begin
          prev_we    = 1'b1;
          prev_waddr = cell_of(after_r);
          prev_wdata = j_r;
        end else begin
          tail_nxt = j_r;
        end
        finish = 1'b1;
      end
      S_HEAD2: begin
        prev_we    = 1'b1;
        prev_waddr = cell_of(x_r);
        prev_wdata = j_r;
        finish     = 1'b1;
      end
      S_POP: begin
        fin_pk = key_rd_r;
        fin_ph = handle_rd_r;
        if (next_q != slpq_pkg::NIL_IDX) begin
          prev_we    = 1'b1;
          prev_waddr = cell_of(next_q);
          head_nxt   = next_q;
        end else begin
          head_nxt = slpq_pkg::NIL_IDX;
          tail_nxt = slpq_pkg::NIL_IDX;
        end
        // freed cell goes to the front of the free chain
        next_we       = 1'b1;
        next_waddr    = cell_of(head_r);
        next_wdata    = free_head_r;
        free_head_nxt = head_r;
        finish        = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      out_res_nxt   = '{status:        fin_status,
                        popped_key:    fin_pk,
                        popped_handle: fin_ph,
                        occupied:      slpq_pkg::occ_t'(count_nxt)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= slpq_pkg::NIL_IDX;
      tail_r      <= slpq_pkg::NIL_IDX;
      free_head_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    j_r       <= j_nxt;
    x_r       <= x_nxt;
    after_r   <= after_nxt;
    key_r     <= key_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem_r[key_waddr] <= key_wdata;
    end
    key_rd_r <= key_mem_r[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (handle_we) begin
      handle_mem_r[key_waddr] <= handle_wdata;
    end
    handle_rd_r <= handle_mem_r[handle_raddr];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem_r[next_waddr] <= next_wdata;
    end
    next_rd_r     <= next_mem_r[next_raddr];
    next_vld_rd_r <= next_vld_r[next_raddr];
    next_raddr_r  <= next_raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_vld_r <= '0;
    end else if (next_we) begin
      next_vld_r[next_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem_r[prev_waddr] <= prev_wdata;
    end
    prev_rd_r <= prev_mem_r[prev_raddr];
  end

endmodule

// File: design/sorted_list_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_list_priority_queue - 64-entry priority queue on a sorted linked list
// Keeps (key, handle) entries in ascending key order; insert and pop-smallest.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): in_command 0 inserts in_key with
//   in_item_handle, 1 pops the entry with the smallest key. Entries with
//   equal keys leave in the order they arrived.
//   Result channel (out_valid/out_ready): exactly one result beat per input
//   beat, in order. out_status is ok, full (insert refused) or empty (pop on
//   an empty queue); popped key and handle are zero unless a pop succeeds.
//   out_occupied is the entry count after the command.
// Operation
//   A pop reads the head cell and unlinks it. An insert walks the list back
//   from the tail past every entry whose key is larger than the new key,
//   one memory read a step, then links the new cell in; it lands at the head
//   when every held key is larger. Full and empty refusals are answered
//   without touching the list.
//   The back part starts the next command the cycle after the result beat.
// Reset and stalls
//   Reset empties the queue at once; no clearing pass is needed.
//   A two-beat command queue keeps in_ready high while a result waits for
//   out_ready; when it fills, in_ready drops until the back part drains it.
// ----------------------------------------------------------------------------
module sorted_list_priority_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [slpq_pkg::KEY_W-1:0]      in_key,
  input  logic [slpq_pkg::HANDLE_W-1:0]   in_item_handle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [slpq_pkg::STATUS_W-1:0]   out_status,
  output logic [slpq_pkg::KEY_W-1:0]      out_popped_key,
  output logic [slpq_pkg::HANDLE_W-1:0]   out_popped_handle,
  output logic [slpq_pkg::OCC_W-1:0]      out_occupied
);

  // front -> back command queue
  logic           q_valid;
  logic           q_ready;
  slpq_pkg::cmd_t q_cmd;
  slpq_pkg::res_t res;

  slpq_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_key         (in_key),
    .in_item_handle (in_item_handle),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_cmd          (q_cmd)
  );

  // list engine with result register
  slpq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_status        = res.status;
  assign out_popped_key    = res.popped_key;
  assign out_popped_handle = res.popped_handle;
  assign out_occupied      = res.occupied;

endmodule

// File: design/slpq_checker.sv
// ----------------------------------------------------------------------------
// slpq_checker - port-level checks for the sorted list priority queue
// Watches both channels for stall behaviour, refusal codes and reset.
// ----------------------------------------------------------------------------
module slpq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_command,
  input logic [slpq_pkg::KEY_W-1:0]      in_key,
  input logic [slpq_pkg::HANDLE_W-1:0]   in_item_handle,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [slpq_pkg::STATUS_W-1:0]   out_status,
  input logic [slpq_pkg::KEY_W-1:0]      out_popped_key,
  input logic [slpq_pkg::HANDLE_W-1:0]   out_popped_handle,
  input logic [slpq_pkg::OCC_W-1:0]      out_occupied
);

  // waiting input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_command) &&
    $stable(in_key) && $stable(in_item_handle))
    else $error("input beat changed while waiting");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_popped_key) && $stable(out_popped_handle) && $stable(out_occupied))
    else $error("result beat changed while stalled");

  // full refusal only at capacity, nothing popped
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == slpq_pkg::ST_FULL |->
    out_occupied == slpq_pkg::occ_t'(slpq_pkg::CAPACITY) &&
    out_popped_key == '0 && out_popped_handle == '0)
    else $error("full status with wrong occupancy or popped data");

  // empty refusal only when nothing held
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == slpq_pkg::ST_EMPTY |->
    out_occupied == '0 && out_popped_key == '0 && out_popped_handle == '0)
    else $error("empty status with entries held or popped data");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind sorted_list_priority_queue slpq_checker u_slpq_checker (.*);

// File: tb/tb_sorted_list_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_list_priority_queue - self-checking bench for the sorted queue
// Drives insert and pop beats through the valid/ready input channel, keeps a
// behavioural model of the sorted list (stable for equal keys) and checks
// every result beat field by field, in order, under four idling regimes.
// ----------------------------------------------------------------------------
module tb_sorted_list_priority_queue;
  import slpq_pkg::*;

  // The limit sits far above the slowest legal run, leaving ample headroom.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Drain tail after the last result, to catch a stray beat.
  localparam int TAIL_CYCLES = 12;
  localparam int MIX_BEATS   = 150;

  typedef struct packed {
    key_t    key;
    handle_t handle;
  } entry_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_command;
  logic [KEY_W-1:0]    in_key;
  logic [HANDLE_W-1:0] in_item_handle;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [KEY_W-1:0]    out_popped_key;
  logic [HANDLE_W-1:0] out_popped_handle;
  logic [OCC_W-1:0]    out_occupied;

  // Model state: the held entries, ascending by key, oldest first on ties
  entry_t held_q[$];
  // Results owed by the block, oldest at the front
  res_t   owed_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int cycle_count;
  int beats_sent;
  int n_pops;
  int n_full;
  int n_empty;
  int n_head_ins;
  int n_tie_ins;

  sorted_list_priority_queue uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_key            (in_key),
    .in_item_handle    (in_item_handle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_popped_key    (out_popped_key),
    .out_popped_handle (out_popped_handle),
    .out_occupied      (out_occupied)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog: no completion after %0d cycles", CYCLE_LIMIT);
      $display("[sorted_list_priority_queue] ERROR");
      $finish;
    end
  end

  // Receiver: out_ready redrawn every falling edge at the current stall rate
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Apply one command to the model and return the result it owes.
  // Insert walks back from the tail past strictly larger keys, so a new
  // entry lands after any equal keys; pop takes the head.
  function automatic res_t predict_result(cmd_t c);
    res_t   r;
    entry_t e;
    int     pos;
    r.status        = ST_OK;
    r.popped_key    = '0;
    r.popped_handle = '0;
    if (c.command == CMD_INSERT) begin
      if (held_q.size() >= CAPACITY) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        pos = held_q.size();
        while (pos > 0 && held_q[pos-1].key > c.key) pos--;
        if (pos == 0 && held_q.size() != 0) n_head_ins++;
        if (pos > 0 && held_q[pos-1].key == c.key) n_tie_ins++;
        e.key    = c.key;
        e.handle = c.item_handle;
        held_q.insert(pos, e);
      end
    end else begin
      if (held_q.size() == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        e               = held_q.pop_front();
        r.popped_key    = e.key;
        r.popped_handle = e.handle;
        n_pops++;
      end
    end
    r.occupied = occ_t'(held_q.size());
    return r;
  endfunction

  // Result checker: every accepted result beat against the oldest owed one
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_q.size() == 0) begin
        $error("result beat with nothing owed: status %0d key %h handle %h occ %0d",
               out_status, out_popped_key, out_popped_handle, out_occupied);
        fail_count++;
      end else begin
        want = owed_q.pop_front();
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_popped_key !== want.popped_key) begin
          $error("out_popped_key: expected %h, got %h", want.popped_key, out_popped_key);
          fail_count++;
        end
        if (out_popped_handle !== want.popped_handle) begin
          $error("out_popped_handle: expected %h, got %h",
                 want.popped_handle, out_popped_handle);
          fail_count++;
        end
        if (out_occupied !== want.occupied) begin
          $error("out_occupied: expected %0d, got %0d", want.occupied, out_occupied);
          fail_count++;
        end
      end
    end
  end

  // Send one beat. Entered and left at a falling edge; in_valid stays high
  // across back-to-back beats and is only lowered when the sender idles.
  task automatic send_beat(input logic cmd, input key_t key, input handle_t hnd);
    cmd_t c;
    c.command     = cmd;
    c.key         = key;
    c.item_handle = hnd;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_key         <= key;
    in_item_handle <= hnd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    owed_q.push_back(predict_result(c));
    beats_sent++;
    @(negedge clk);
  endtask

  // Hold the input side off until every owed result has come back
  task automatic wait_results_home();
    in_valid <= 1'b0;
    @(negedge clk);
    while (owed_q.size() != 0) @(negedge clk);
  endtask

  // Keys: a crowded band for ties, the two extremes, or anything
  function automatic key_t pick_key();
    case ($urandom_range(3))
      0:       return key_t'($urandom_range(7));
      1:       return $urandom_range(1) ? '1 : '0;
      default: return key_t'($urandom());
    endcase
  endfunction

  // Empty pop, head, tail, middle and tie inserts, key and handle extremes,
  // then pops until the queue reports empty again.
  task automatic test_directed();
    send_beat(CMD_POP,    16'h0000, 16'h0000);
    send_beat(CMD_INSERT, 16'd1000, 16'h0001);
    send_beat(CMD_INSERT, 16'd500,  16'h0002);
    send_beat(CMD_INSERT, 16'd2000, 16'h0004);
    send_beat(CMD_INSERT, 16'd1000, 16'h0008);
    send_beat(CMD_INSERT, 16'd1000, 16'h0010);
    send_beat(CMD_INSERT, 16'h0000, 16'hFFFF);
    send_beat(CMD_INSERT, 16'hFFFF, 16'h0000);
    send_beat(CMD_INSERT, 16'hFFFF, 16'hAAAA);
    send_beat(CMD_INSERT, 16'h0000, 16'h5555);
    send_beat(CMD_INSERT, 16'd1500, 16'h1234);
    wait_results_home();
    repeat (11) send_beat(CMD_POP, 16'hFFFF, 16'hFFFF);
  endtask

  // Fill to capacity with random content, knock on the door twice at full,
  // then drain back past empty.
  task automatic test_fill_and_overflow();
    while (held_q.size() < CAPACITY) send_beat(CMD_INSERT, pick_key(), handle_t'($urandom()));
    send_beat(CMD_INSERT, 16'h0000, 16'hFFFF);
    send_beat(CMD_INSERT, 16'hFFFF, 16'h0000);
    while (held_q.size() != 0) send_beat(CMD_POP, key_t'($urandom()), handle_t'($urandom()));
    send_beat(CMD_POP, key_t'($urandom()), handle_t'($urandom()));
  endtask

  // Random mix steered towards a fill level that moves every 40 beats, so
  // the list spends time shallow, deep, full and empty.
  task automatic test_random_mix(input int n);
    int   target;
    int   ins_pct;
    logic cmd;
    target = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) target = $urandom_range(CAPACITY);
      if (held_q.size() < target)      ins_pct = 75;
      else if (held_q.size() > target) ins_pct = 25;
      else                             ins_pct = 50;
      cmd = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_POP;
      send_beat(cmd, pick_key(), handle_t'($urandom()));
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_INSERT;
    in_key         = '0;
    in_item_handle = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fail_count     = 0;
    cycle_count    = 0;
    beats_sent     = 0;
    n_pops         = 0;
    n_full         = 0;
    n_empty        = 0;
    n_head_ins     = 0;
    n_tie_ins      = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phases: free-running, sender gaps, receiver stalls, then both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (ph == 0) test_directed();
      test_random_mix(MIX_BEATS);
      if (ph == 1 || ph == 3) test_fill_and_overflow();
      wait_results_home();
    end

    // Let any stray beat show itself before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_q.size() != 0) begin
      $error("%0d results still owed at the end", owed_q.size());
      fail_count++;
    end

    $display("covered %0d beats: %0d pops, %0d full and %0d empty refusals,",
             beats_sent, n_pops, n_full, n_empty);
    $display("  %0d inserts at the head, %0d behind equal keys; %0d mismatches",
             n_head_ins, n_tie_ins, fail_count);
    if (fail_count == 0) $display("[sorted_list_priority_queue] OK");
    else                 $display("[sorted_list_priority_queue] ERROR");
    $finish;
  end

endmodule
